// File: design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and the head-of-hold decode for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned HOLD_DEPTH = 4;
  localparam int unsigned CP_W       = 21;
  localparam int unsigned CNT_W      = 3;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  // Lead and continuation byte patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] PAYLOAD6   = 8'h3F;

  typedef logic [HOLD_DEPTH-1:0][7:0] hold_vec_t;

  // Outcome of decoding the sequence at the head of the hold
  typedef struct packed {
    logic             emit;
    logic             clr;
    logic [CNT_W-1:0] drop;
    logic [CP_W-1:0]  cp;
  } decode_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic step;
  } u8d_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic last;
    logic out_free;
  } u8d_status_t;

  // Decode the head sequence of the hold; only entries below cnt are used
  function automatic decode_t decode_head(hold_vec_t b, logic [CNT_W-1:0] cnt, logic fin);
    decode_t          d;
    logic [1:0]       extra;
    logic [CNT_W-1:0] need;
    logic             bad;
    logic [CP_W-1:0]  acc;
    d     = '0;
    extra = 2'd0;
    acc   = '0;
    if ((b[0] & LEAD2_MASK) == LEAD2_CODE) begin
      extra = 2'd1;
      acc   = {10'b0, b[0][4:0], b[1][5:0]};
    end else if ((b[0] & LEAD3_MASK) == LEAD3_CODE) begin
      extra = 2'd2;
      acc   = {5'b0, b[0][3:0], b[1][5:0], b[2][5:0]};
    end else if ((b[0] & LEAD4_MASK) == LEAD4_CODE) begin
      extra = 2'd3;
      acc   = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    end
    need = {1'b0, extra} + 3'd1;
    bad  = ((extra >= 2'd1) && ((b[1] & CONT_MASK) != CONT_CODE))
        || ((extra >= 2'd2) && ((b[2] & CONT_MASK) != CONT_CODE))
        || ((extra == 2'd3) && ((b[3] & CONT_MASK) != CONT_CODE));
    if (cnt == '0) begin
      d.emit = 1'b0;
    end else if (b[0][7] == 1'b0) begin
      // Plain byte
      d.emit = 1'b1;
      d.cp   = {13'b0, b[0]};
      d.drop = 3'd1;
    end else if (extra == 2'd0) begin
      // Stray or invalid lead
      d.emit = 1'b1;
      d.cp   = REPLACEMENT;
      d.drop = 3'd1;
    end else if (cnt < need) begin
      // Incomplete: wait, or give one replacement at the end of the text
      d.emit = fin;
      d.clr  = fin;
      d.cp   = REPLACEMENT;
    end else if (bad) begin
      d.emit = 1'b1;
      d.cp   = REPLACEMENT;
      d.drop = 3'd1;
    end else begin
      d.emit = 1'b1;
      d.cp   = acc;
      d.drop = need;
    end
    return d;
  endfunction

endpackage

// File: design/u8d_ctrl.sv
// ----------------------------------------------------------------------------
// u8d_ctrl
// Controller: takes one byte, then steps the datapath once per result.
// ----------------------------------------------------------------------------
module u8d_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  u8d_pkg::u8d_status_t status,
  output u8d_pkg::u8d_cmd_t    cmd
);
  import u8d_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the work on one item
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status.emit) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/u8d_datapath.sv
// ----------------------------------------------------------------------------
// u8d_datapath
// Byte hold, head decode with one-step lookahead, and the output register.
// ----------------------------------------------------------------------------
module u8d_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  u8d_pkg::u8d_cmd_t    cmd,
  output u8d_pkg::u8d_status_t status,
  input  logic [7:0]           s_tdata,   // [7:0] text_byte
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [20:0] code_point, [23:21] zero
  output logic                 m_tuser,   // [0] run_last
  output logic                 m_tlast
);
  import u8d_pkg::*;

  hold_vec_t        held;
  logic [CNT_W-1:0] cnt;
  logic             fin;
  logic [CP_W-1:0]  cp_q;

  decode_t          cur;
  decode_t          nxt;
  hold_vec_t        held_next;
  logic [CNT_W-1:0] cnt_next;

  // Decode the head, then what the head would be after this result
  always_comb begin
    cur       = decode_head(held, cnt, fin);
    held_next = held >> {cur.drop, 3'b000};
    cnt_next  = cur.clr ? '0 : (cnt - cur.drop);
    nxt       = decode_head(held_next, cnt_next, fin);
  end

  assign status.emit     = cur.emit;
  assign status.last     = !nxt.emit;
  assign status.out_free = !m_tvalid || m_tready;

  // Hold bytes: append on take, drop the consumed head on step
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held[cnt[1:0]] <= s_tdata;
      fin            <= s_tlast;
    end else if (cmd.step) begin
      held <= held_next;
    end
  end

  // Hold count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.take) begin
      cnt <= cnt + 3'd1;
    end else if (cmd.step) begin
      cnt <= cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      cp_q    <= cur.cp;
      m_tuser <= !nxt.emit;
      m_tlast <= !nxt.emit && fin;
    end
  end

  assign m_tdata = {3'b000, cp_q};

endmodule

// File: design/utf8_stream_decoder_unit.sv
// A byte is taken in the idle state; its first result is registered by the first step
// in the evaluate state. The controller steps one head sequence of the hold per cycle
// while the output is free; a byte causes 0 to 4 results, all out before the next byte.
// Output stalls hold the stepping but a finished result does not block the next byte.
// Reset (rst, synchronous, active high) empties the hold and the output register.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 byte to code point decoder with replacement on bad input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // text_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // [0] run_last
  output logic        m_tlast    // text_done
);
  import u8d_pkg::*;

  u8d_cmd_t    cmd;
  u8d_status_t status;

  u8d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  u8d_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tuser,   // [0] run_last
  input logic        m_tlast
);

  // A stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output item changed while stalled");

  // The end of a text always closes the run of its final byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("text_done without run_last");

  // Code points stay within 21 bits
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'b000)
    else $error("padding bits of code point set");

  // One byte at a time: evaluation follows every accepted byte
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("byte taken while previous byte still in work");

endmodule

bind utf8_stream_decoder_unit u8d_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: bench/tb_utf8_stream_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Streams directed and random UTF-8 texts into the decoder and compares every
// code point, run_last and text_done against a cycle-free model of the hold.
// Both sides idle at random. One long receiver stall backs up the input, and
// one sender pause lets the decoder drain completely.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_unit;
  import u8d_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BYTES = 224;

  // One expected decoder result
  typedef struct {
    logic [CP_W-1:0] cp;
    logic            run_last;
    logic            text_done;
  } cp_item_t;

  // Model of the byte hold and store of code points still to arrive
  class code_point_board;
    logic [7:0]      held[HOLD_DEPTH];
    int              held_n;
    cp_item_t        want_q[$];
    logic [CP_W-1:0] res_q[$];
    int              errors;
    int              checked;
    int              replacements;

    function new();
      held_n       = 0;
      errors       = 0;
      checked      = 0;
      replacements = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Append one code point released by the current byte
    function void add_res(logic [CP_W-1:0] cp);
      res_q = {res_q, cp};
    endfunction

    // Append one expectation
    function void add_want(cp_item_t e);
      want_q = {want_q, e};
    endfunction

    // Shift the hold down by n bytes
    function void drop_held(int n);
      if (n >= held_n) begin
        held_n = 0;
        return;
      end
      for (int i = 0; i < held_n - n; i++) held[i] = held[i + n];
      held_n = held_n - n;
    endfunction

    // Take one accepted byte and queue the code points it releases
    function void note_byte(logic [7:0] b, logic fin);
      logic [7:0]      lead;
      logic [CP_W-1:0] acc;
      int              extra;
      bit              bad;
      cp_item_t        e;
      res_q.delete();
      if (held_n >= HOLD_DEPTH) held_n = 0;
      held[held_n] = b;
      held_n++;
      while (held_n > 0 && res_q.size() < HOLD_DEPTH) begin
        lead = held[0];
        if (lead[7] == 1'b0) begin
          add_res({13'b0, lead});
          drop_held(1);
          continue;
        end
        if ((lead & LEAD2_MASK) == LEAD2_CODE) begin
          extra = 1;
          acc   = {13'b0, lead & 8'h1F};
        end else if ((lead & LEAD3_MASK) == LEAD3_CODE) begin
          extra = 2;
          acc   = {13'b0, lead & 8'h0F};
        end else if ((lead & LEAD4_MASK) == LEAD4_CODE) begin
          extra = 3;
          acc   = {13'b0, lead & 8'h07};
        end else begin
          extra = 0;
          acc   = '0;
        end
        // Stray continuation or invalid lead
        if (extra == 0) begin
          add_res(REPLACEMENT);
          drop_held(1);
          continue;
        end
        // Incomplete: wait, or one replacement if the text has ended
        if (held_n < extra + 1) begin
          if (fin) begin
            add_res(REPLACEMENT);
            held_n = 0;
          end
          break;
        end
        bad = 1'b0;
        for (int k = 1; k <= extra; k++) begin
          if ((held[k] & CONT_MASK) != CONT_CODE) begin
            bad = 1'b1;
            break;
          end
          acc = (acc << 6) | {13'b0, held[k] & PAYLOAD6};
        end
        if (bad) begin
          add_res(REPLACEMENT);
          drop_held(1);
        end else begin
          add_res(acc);
          drop_held(extra + 1);
        end
      end
      if (fin) held_n = 0;
      foreach (res_q[i]) begin
        e.cp        = res_q[i];
        e.run_last  = (i == res_q.size() - 1);
        e.text_done = e.run_last && fin;
        add_want(e);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [23:0] data, logic run_last, logic text_done);
      cp_item_t e;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                 $time, data, run_last, text_done);
        return;
      end
      e = want_q.pop_front();
      checked++;
      if (e.cp == REPLACEMENT) replacements++;
      if (data !== {3'b000, e.cp}) begin
        errors++;
        $display("%0t: code_point expected %h actual %h", $time, {3'b000, e.cp}, data);
      end
      if (run_last !== e.run_last) begin
        errors++;
        $display("%0t: run_last expected %b actual %b", $time, e.run_last, run_last);
      end
      if (text_done !== e.text_done) begin
        errors++;
        $display("%0t: text_done expected %b actual %b", $time, e.text_done, text_done);
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] text_byte
  logic        s_tlast  = 1'b0;    // text_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [20:0] code_point, [23:21] zero
  logic        m_tuser;            // [0] run_last
  logic        m_tlast;            // text_done

  code_point_board board;
  int          cycles       = 0;
  int          results_seen = 0;
  int          rx_wait      = 0;
  bit          long_done    = 1'b0;
  int          bytes_sent   = 0;
  int          texts_sent   = 0;
  logic [8:0]  stim_q[$];

  utf8_stream_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lead byte of a well-formed sequence of len bytes
  function automatic logic [7:0] make_lead(int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] make_cont();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // Append one {text_end, text_byte} entry to the random stimulus
  function automatic void add_stim(logic [8:0] v);
    stim_q = {stim_q, v};
  endfunction

  // Offer one item after a gap and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic fin, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, fin);
    bytes_sent++;
    if (fin) texts_sent++;
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: check accepted results and stall at random, once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        board.check_result(m_tdata, m_tuser, m_tlast);
        results_seen++;
      end
      if (results_seen == 80 && !long_done) begin
        rx_wait   = 400;
        long_done = 1'b1;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_wait = gap_len(((cycles / 700) % 4) == 1);
      end
    end
  end

  // Stimulus
  initial begin
    logic [8:0] directed [26];
    logic [7:0] b;
    int         n_chars;
    int         r;
    int         len;
    int         k;
    bit         cut;
    bit         calm;

    // {text_end, text_byte}
    directed = '{
      9'h000, 9'h07F,                       // plain extremes
      9'h080, 9'h0F8, 9'h1FF,               // stray and invalid leads, end of text
      9'h0C2, 9'h0A9,                       // two-byte character
      9'h0E2, 9'h082, 9'h0AC,               // three-byte character
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,       // four-byte character
      9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,       // widest code point as the final character
      9'h0C3, 9'h041,                       // bad continuation straight after a lead
      9'h0F0, 9'h080, 9'h080, 9'h041,       // bad continuation after two good ones
      9'h0E2, 9'h182                        // sequence cut off by the end of text
    };

    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8], gap_len(1'b0));

    // Pause until the decoder has drained
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    // Build random texts: mostly well-formed characters, some noise
    while (stim_q.size() < RANDOM_BYTES) begin
      n_chars = $urandom_range(1, 8);
      cut     = 1'b0;
      for (int c = 0; c < n_chars && !cut; c++) begin
        r   = $urandom_range(0, 99);
        len = $urandom_range(1, 4);
        if (r < 70) begin
          add_stim({1'b0, make_lead(len)});
          repeat (len - 1) add_stim({1'b0, make_cont()});
        end else if (r < 85) begin
          b = 8'($urandom);
          add_stim({1'b0, b});
        end else if (r < 95) begin
          // Broken sequence: too few continuations, then a non-continuation
          len = $urandom_range(2, 4);
          add_stim({1'b0, make_lead(len)});
          k = $urandom_range(0, len - 2);
          repeat (k) add_stim({1'b0, make_cont()});
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          add_stim({1'b0, b});
        end else begin
          // Cut off by the end of text
          len = $urandom_range(2, 4);
          add_stim({1'b0, make_lead(len)});
          k = $urandom_range(0, len - 2);
          repeat (k) add_stim({1'b0, make_cont()});
          cut = 1'b1;
        end
      end
      stim_q[stim_q.size() - 1][8] = 1'b1;
    end

    // Drive them, some texts with no idling at all
    calm = ($urandom_range(0, 3) == 0);
    foreach (stim_q[i]) begin
      send_byte(stim_q[i][7:0], stim_q[i][8], gap_len(calm));
      if (stim_q[i][8]) calm = ($urandom_range(0, 3) == 0);
    end

    // Drain and let the pipeline settle
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d texts; checked %0d code points, %0d replacements.",
             bytes_sent, texts_sent, board.checked, board.replacements);
    $display("Receiver held off once for 400 cycles; sender paused once for a full drain.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
